[rtl/core/apn_pkg.sv]
// apn_pkg: shared types, constants, microcode rom and sample helpers
// for the audio peak normalizer; no dependencies
package apn_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DIV_W    = 17;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W = 2;

    // twice the full-scale value per format
    localparam logic [DIV_W-1:0] FULL2_8  = 17'd256;
    localparam logic [DIV_W-1:0] FULL2_16 = 17'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE   = 2'd1;

    // datapath operations
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_READ  = 4'd2;
    localparam logic [3:0] OP_PEAK  = 4'd3;
    localparam logic [3:0] OP_DIVL  = 4'd4;
    localparam logic [3:0] OP_TAKEL = 4'd5;
    localparam logic [3:0] OP_DIVR  = 4'd6;
    localparam logic [3:0] OP_TAKER = 4'd7;
    localparam logic [3:0] OP_MUL   = 4'd8;
    localparam logic [3:0] OP_EMIT  = 4'd9;

    // wait conditions
    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_END  = 2'd1;
    localparam logic [1:0] W_DIV  = 2'd2;
    localparam logic [1:0] W_OUT  = 2'd3;

    // branch kinds
    localparam logic [1:0] B_NEXT = 2'd0;
    localparam logic [1:0] B_JUMP = 2'd1;
    localparam logic [1:0] B_LOOP = 2'd2;

    // program steps
    localparam logic [STEP_W-1:0] S_LOAD  = 4'd0;
    localparam logic [STEP_W-1:0] S_SRD   = 4'd1;
    localparam logic [STEP_W-1:0] S_PEAK  = 4'd2;
    localparam logic [STEP_W-1:0] S_DIVL  = 4'd3;
    localparam logic [STEP_W-1:0] S_TAKEL = 4'd4;
    localparam logic [STEP_W-1:0] S_DIVR  = 4'd5;
    localparam logic [STEP_W-1:0] S_TAKER = 4'd6;
    localparam logic [STEP_W-1:0] S_ERD   = 4'd7;
    localparam logic [STEP_W-1:0] S_MUL   = 4'd8;
    localparam logic [STEP_W-1:0] S_EMIT  = 4'd9;
    localparam logic [STEP_W-1:0] S_DONE  = 4'd10;

    typedef struct packed {
        logic [3:0]        op;
        logic [1:0]        wt;
        logic [1:0]        br;
        logic [STEP_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quo;
    } t_div_stat;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            S_LOAD:  w = '{op: OP_LOAD,  wt: W_END,  br: B_NEXT, tgt: S_LOAD};
            S_SRD:   w = '{op: OP_READ,  wt: W_NONE, br: B_NEXT, tgt: S_LOAD};
            S_PEAK:  w = '{op: OP_PEAK,  wt: W_NONE, br: B_LOOP, tgt: S_SRD};
            S_DIVL:  w = '{op: OP_DIVL,  wt: W_NONE, br: B_NEXT, tgt: S_LOAD};
            S_TAKEL: w = '{op: OP_TAKEL, wt: W_DIV,  br: B_NEXT, tgt: S_LOAD};
            S_DIVR:  w = '{op: OP_DIVR,  wt: W_NONE, br: B_NEXT, tgt: S_LOAD};
            S_TAKER: w = '{op: OP_TAKER, wt: W_DIV,  br: B_NEXT, tgt: S_LOAD};
            S_ERD:   w = '{op: OP_READ,  wt: W_NONE, br: B_NEXT, tgt: S_LOAD};
            S_MUL:   w = '{op: OP_MUL,   wt: W_NONE, br: B_NEXT, tgt: S_LOAD};
            S_EMIT:  w = '{op: OP_EMIT,  wt: W_OUT,  br: B_LOOP, tgt: S_ERD};
            S_DONE:  w = '{op: OP_NOP,   wt: W_NONE, br: B_JUMP, tgt: S_LOAD};
            default: w = '{op: OP_NOP,   wt: W_NONE, br: B_JUMP, tgt: S_LOAD};
        endcase
        return w;
    endfunction

    // raw bits to signed sample value
    function automatic logic signed [SAMPLE_W-1:0] sample_value(
        input logic [SAMPLE_W-1:0] raw,
        input logic                fmt
    );
        logic signed [SAMPLE_W-1:0] v;
        v = fmt ? $signed(raw) : $signed({8'h00, raw[7:0]});
        return v;
    endfunction

endpackage

[rtl/core/apn_ifs.sv]
// apn_ifs: valid/ready channel interfaces for sample input, sample output
// and configuration writes; depends on apn_pkg
interface apn_in_if;
    logic                          valid;
    logic                          ready;
    logic [apn_pkg::SAMPLE_W-1:0]  sample_in;
    logic                          frame_end;
    modport source (output valid, output sample_in, output frame_end, input ready);
    modport sink (input valid, input sample_in, input frame_end, output ready);
endinterface

interface apn_out_if;
    logic                          valid;
    logic                          ready;
    logic [apn_pkg::SAMPLE_W-1:0]  sample_out;
    logic                          last_out;
    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

interface apn_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [apn_pkg::CFG_IDX_W-1:0] index;
    logic                          data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/audio_peak_normalizer.sv]
// audio_peak_normalizer: frame store, per-channel peak search, gain divide
// and scaled output, run by a microcoded step sequencer
// depends on apn_pkg, apn_ifs, apn_ram, apn_div
//
//   port     dir  kind   carries
//   i_samp   in   item   sample_in, frame_end
//   o_samp   out  item   sample_out, last_out
//   i_cfg    in   write  index, data (sample_format, stereo_mode)
//
// loading takes one item per cycle in the load step; each frame then passes a
// two-step peak scan, two divides and three steps per output
// through the single ram read port before the next item is taken
// synchronous active-low reset clears control state; the ram is not cleared
// output stalls hold the emit step; config writes are taken every cycle
module audio_peak_normalizer #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    apn_in_if.sink    i_samp,
    apn_out_if.source o_samp,
    apn_cfg_if.sink   i_cfg
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = apn_pkg::SAMPLE_W;
    localparam int DW = apn_pkg::DIV_W;

    apn_pkg::t_uword    w_uw;
    apn_pkg::t_div_stat w_div;

    logic [apn_pkg::STEP_W-1:0] r_step, n_step;
    logic [CW-1:0]              r_fill;
    logic [CW-1:0]              r_count;
    logic [AW-1:0]              r_idx;
    logic                       r_fmt;
    logic                       r_stereo;
    logic signed [SW-1:0]       r_lp;
    logic signed [SW-1:0]       r_rp;
    logic [SW-1:0]              r_gl;
    logic [SW-1:0]              r_gr;
    logic signed [32:0]         r_prod;
    logic                       r_out_valid;
    logic [SW-1:0]              r_out_sample;
    logic                       r_out_last;

    logic                 w_in_acc;
    logic                 w_cfg_acc;
    logic                 w_hold;
    logic                 w_fire;
    logic                 w_last;
    logic [CW-1:0]        w_cnt_m1;
    logic                 w_room;
    logic [CW-1:0]        w_fill_nx;
    logic [SW-1:0]        w_rdata;
    logic signed [SW-1:0] w_val;
    logic                 w_right;
    logic signed [SW-1:0] w_peak;
    logic                 w_pos;
    logic                 w_div_start;
    logic [DW-1:0]        w_num;
    logic [DW-1:0]        w_den;
    logic signed [DW-1:0] w_gain_s;
    logic signed [32:0]   w_prod;
    logic [SW-1:0]        w_sat;

    assign w_uw      = apn_pkg::ucode(r_step);
    assign w_in_acc  = i_samp.valid && i_samp.ready;
    assign w_cfg_acc = i_cfg.valid && i_cfg.ready;
    assign w_room    = (r_fill < CW'(DEPTH));
    assign w_fill_nx = w_room ? (r_fill + CW'(1)) : r_fill;
    assign w_cnt_m1  = r_count - CW'(1);
    assign w_last    = (r_idx == w_cnt_m1[AW-1:0]);
    assign w_right   = r_stereo && r_idx[0];
    assign w_val     = apn_pkg::sample_value(w_rdata, r_fmt);

    assign i_samp.ready = (w_uw.op == apn_pkg::OP_LOAD);
    assign i_cfg.ready  = 1'b1;

    // sequencer
    always_comb begin
        case (w_uw.wt)
            apn_pkg::W_NONE: w_hold = 1'b0;
            apn_pkg::W_END:  w_hold = !(w_in_acc && i_samp.frame_end);
            apn_pkg::W_DIV:  w_hold = w_div.busy;
            apn_pkg::W_OUT:  w_hold = r_out_valid && !o_samp.ready;
            default:         w_hold = 1'b0;
        endcase
        w_fire = !w_hold;
        n_step = r_step;
        if (w_fire) begin
            case (w_uw.br)
                apn_pkg::B_NEXT: n_step = r_step + apn_pkg::STEP_W'(1);
                apn_pkg::B_JUMP: n_step = w_uw.tgt;
                apn_pkg::B_LOOP: n_step = w_last ? (r_step + apn_pkg::STEP_W'(1)) : w_uw.tgt;
                default:         n_step = apn_pkg::S_LOAD;
            endcase
        end
    end

    // gain divide operands
    assign w_div_start = (w_uw.op == apn_pkg::OP_DIVL) || (w_uw.op == apn_pkg::OP_DIVR);
    assign w_peak      = (w_uw.op == apn_pkg::OP_DIVL) ? r_lp : r_rp;
    assign w_pos       = !w_peak[SW-1] && (w_peak != '0);
    assign w_num = w_pos ? ((r_fmt ? apn_pkg::FULL2_16 : apn_pkg::FULL2_8)
                            + {1'b0, w_peak}) : DW'(1);
    assign w_den = w_pos ? {w_peak, 1'b0} : DW'(1);

    // scaling and saturation
    assign w_gain_s = $signed({1'b0, (w_right ? r_gr : r_gl)});
    assign w_prod   = w_val * w_gain_s;

    always_comb begin
        if (!r_fmt) begin
            if (r_prod < 0) begin
                w_sat = '0;
            end else if (r_prod > 33'sd255) begin
                w_sat = 16'h00ff;
            end else begin
                w_sat = {8'h00, r_prod[7:0]};
            end
        end else begin
            if (r_prod > 33'sd32767) begin
                w_sat = 16'h7fff;
            end else if (r_prod < -33'sd32768) begin
                w_sat = 16'h8000;
            end else begin
                w_sat = r_prod[15:0];
            end
        end
    end

    apn_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_room),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_samp.sample_in),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    apn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= apn_pkg::S_LOAD;
            r_fill      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_fmt       <= 1'b0;
            r_stereo    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (w_cfg_acc) begin
                case (i_cfg.index)
                    apn_pkg::CFG_SAMPLE_FORMAT: r_fmt    <= i_cfg.data;
                    apn_pkg::CFG_STEREO_MODE:   r_stereo <= i_cfg.data;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                if (i_samp.frame_end) begin
                    r_count <= w_fill_nx;
                    r_fill  <= '0;
                end else begin
                    r_fill <= w_fill_nx;
                end
            end
            if (w_fire && ((w_uw.op == apn_pkg::OP_PEAK) || (w_uw.op == apn_pkg::OP_EMIT))) begin
                r_idx <= w_last ? '0 : (r_idx + AW'(1));
            end
            if (w_fire && (w_uw.op == apn_pkg::OP_EMIT)) begin
                r_out_valid <= 1'b1;
            end else if (o_samp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_uw.op == apn_pkg::OP_PEAK) begin
            if (w_right) begin
                if ((r_idx == AW'(1)) || (w_val > r_rp)) begin
                    r_rp <= w_val;
                end
            end else begin
                if ((r_idx == '0) || (w_val > r_lp)) begin
                    r_lp <= w_val;
                end
            end
        end
        if (w_fire && (w_uw.op == apn_pkg::OP_TAKEL)) begin
            r_gl <= w_div.quo[SW-1:0];
        end
        if (w_fire && (w_uw.op == apn_pkg::OP_TAKER)) begin
            r_gr <= w_div.quo[SW-1:0];
        end
        if (w_uw.op == apn_pkg::OP_MUL) begin
            r_prod <= w_prod;
        end
        if (w_fire && (w_uw.op == apn_pkg::OP_EMIT)) begin
            r_out_sample <= w_sat;
            r_out_last   <= w_last;
        end
    end

    assign o_samp.valid      = r_out_valid;
    assign o_samp.sample_out = r_out_sample;
    assign o_samp.last_out   = r_out_last;

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != apn_pkg::S_LOAD) |-> (r_count != '0))
        else $error("frame processed with empty count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div.busy)
        else $error("divider started while busy");

endmodule

[rtl/core/apn_ram.sv]
// apn_ram: generic single write port, single read port ram with
// registered read data; no dependencies
module apn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/apn_div.sv]
// apn_div: restoring unsigned divider, one quotient bit per cycle
// depends on apn_pkg
module apn_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [apn_pkg::DIV_W-1:0] i_num,
    input  logic [apn_pkg::DIV_W-1:0] i_den,
    output apn_pkg::t_div_stat        o_stat
);

    localparam int W  = apn_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_den, n_den;
    logic [W:0]    w_sh;
    logic [W:0]    w_diff;

    assign w_sh   = {r_rem, r_quo[W-1]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                n_rem = w_diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - CW'(1);
            n_busy = (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.quo  = r_quo;

endmodule

[tb/audio_peak_normalizer_tb.sv]
// audio_peak_normalizer_tb: self-checking bench for the peak normalizer; frames of
// random and corner samples with random gaps and stalls, checked by a frame scoreboard
// depends on apn_pkg, apn_ifs and audio_peak_normalizer
`timescale 1ns / 100ps

module audio_peak_normalizer_tb;

    localparam int FRAME_DEPTH = 64;

    typedef struct {
        logic [apn_pkg::SAMPLE_W-1:0] sample;
        logic                         last;
    } t_scaled_item;

    class normalized_frame_board;
        bit                           fmt16;
        bit                           stereo;
        logic [apn_pkg::SAMPLE_W-1:0] frame_q[$];
        t_scaled_item                 scaled_due[$];
        int                           mismatches;
        int                           checked;
        int                           frames;

        function int level(logic [apn_pkg::SAMPLE_W-1:0] raw);
            int v;
            if (fmt16) begin
                v = int'($signed(raw));
                return v;
            end
            return int'(raw[7:0]);
        endfunction

        function int gain(int peak);
            int full2;
            full2 = fmt16 ? 65536 : 256;
            if (peak <= 0) return 1;
            return (full2 + peak) / (2 * peak);
        endfunction

        function logic [apn_pkg::SAMPLE_W-1:0] scaled(logic [apn_pkg::SAMPLE_W-1:0] raw,
                                                      int g);
            longint v;
            v = longint'(level(raw)) * g;
            if (fmt16) begin
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end else begin
                if (v > 255) v = 255;
                if (v < 0) v = 0;
            end
            return v[15:0];
        endfunction

        function void take_sample(logic [apn_pkg::SAMPLE_W-1:0] raw, bit fe);
            int n;
            int lp;
            int rp;
            int lg;
            int rg;
            int v;
            bit right;
            t_scaled_item e;
            if (frame_q.size() < FRAME_DEPTH) frame_q.push_back(raw);
            if (!fe) return;
            n = frame_q.size();
            lp = 0;
            rp = 0;
            for (int i = 0; i < n; i++) begin
                v = level(frame_q[i]);
                right = stereo && (i % 2 == 1);
                if (right) begin
                    if (i == 1 || v > rp) rp = v;
                end else begin
                    if (i == 0 || v > lp) lp = v;
                end
            end
            lg = gain(lp);
            rg = gain(rp);
            for (int i = 0; i < n; i++) begin
                right = stereo && (i % 2 == 1);
                e.sample = scaled(frame_q[i], right ? rg : lg);
                e.last = (i == n - 1);
                scaled_due.push_back(e);
            end
            frame_q.delete();
            frames++;
        endfunction

        function void match_scaled(logic [apn_pkg::SAMPLE_W-1:0] s, logic l);
            t_scaled_item e;
            checked++;
            if (scaled_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sample %h last %b", s, l);
                return;
            end
            e = scaled_due.pop_front();
            if (e.sample !== s || e.last !== l) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected sample %h last %b, got sample %h last %b",
                             e.sample, e.last, s, l);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    apn_in_if  in_ch();
    apn_out_if out_ch();
    apn_cfg_if cfg_ch();

    audio_peak_normalizer #(.DEPTH(FRAME_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_samp  (in_ch),
        .o_samp  (out_ch),
        .i_cfg   (cfg_ch)
    );

    normalized_frame_board sb = new();

    logic [apn_pkg::SAMPLE_W-1:0] frame_buf[$];
    bit                           no_gaps;
    int                           items_sent;
    int                           cfg_writes;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("[audio_peak_normalizer] ERROR");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [apn_pkg::SAMPLE_W-1:0] pick_raw(int flavor);
        logic [apn_pkg::SAMPLE_W-1:0] r;
        case (flavor)
            1: begin
                r = 16'($urandom_range(0, 40));
                if ($urandom_range(0, 1)) r = -r;
                if (!sb.fmt16 && $urandom_range(0, 1)) r[15:8] = 8'($urandom_range(0, 255));
            end
            2: begin
                if (sb.fmt16) r = $urandom_range(0, 3) == 0 ? 16'h0000 : {1'b1, 15'($urandom)};
                else r = {8'($urandom), 8'h00};
            end
            3: begin
                case ($urandom_range(0, 7))
                    0: r = 16'h0000;
                    1: r = 16'hFFFF;
                    2: r = 16'h8000;
                    3: r = 16'h7FFF;
                    4: r = 16'h00FF;
                    5: r = 16'h0080;
                    6: r = 16'h007F;
                    default: r = 16'h0001;
                endcase
            end
            default: r = 16'($urandom);
        endcase
        return r;
    endfunction

    task automatic send_sample(input logic [apn_pkg::SAMPLE_W-1:0] raw, input bit fe);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= raw;
        in_ch.frame_end <= fe;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.take_sample(raw, fe);
        items_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_sample(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // block idle: input released and all results back
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.scaled_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(input bit fmt, input bit st);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= apn_pkg::CFG_SAMPLE_FORMAT;
        cfg_ch.data  <= fmt;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.fmt16 = fmt;
        cfg_ch.index <= apn_pkg::CFG_STEREO_MODE;
        cfg_ch.data  <= st;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.stereo = st;
        cfg_ch.valid <= 1'b0;
        cfg_writes += 2;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.match_scaled(out_ch.sample_out, out_ch.last_out);
    end

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) repeat ($urandom_range(50, 200)) @(posedge i_clk);
            else repeat ($urandom_range(1, 6)) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        int len;
        int flavor;
        int rf;
        int wait_cycles;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        in_ch.frame_end <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= apn_pkg::CFG_SAMPLE_FORMAT;
        cfg_ch.data     <= 1'b0;
        no_gaps = 1'b0;
        items_sent = 0;
        cfg_writes = 0;
        wait_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 8-bit mono: full scale, ignored high byte, zero peak, tiny peak
        write_config(1'b0, 1'b0);
        frame_buf = {16'h00FF, 16'hAB01, 16'h0000};
        send_frame();
        frame_buf = {16'h0000};
        send_frame();
        frame_buf = {16'h0001};
        send_frame();
        frame_buf = {16'h0003, 16'hFF01};
        send_frame();

        // 16-bit mono: full scale, negative peak, saturation both ways
        settle();
        write_config(1'b1, 1'b0);
        frame_buf = {16'h7FFF, 16'h8000};
        send_frame();
        frame_buf = {16'h8000, 16'hFFFF};
        send_frame();
        frame_buf = {16'h0001, 16'hFFFF, 16'h8000};
        send_frame();

        // 16-bit stereo: lone left sample, negative right channel
        settle();
        write_config(1'b1, 1'b1);
        frame_buf = {16'h0100};
        send_frame();
        frame_buf = {16'h0010, 16'hFFF0, 16'h4000, 16'h8001};
        send_frame();

        // 8-bit stereo
        settle();
        write_config(1'b0, 1'b1);
        frame_buf = {16'h0040, 16'h00C8, 16'h0000, 16'h0001};
        send_frame();

        rf = 0;
        while (items_sent < 415) begin
            if ($urandom_range(0, 3) == 0) begin
                settle();
                write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            no_gaps = ($urandom_range(0, 4) == 0);
            if (rf == 3) len = FRAME_DEPTH;
            else if (rf == 6) len = FRAME_DEPTH + 4;
            else begin
                case ($urandom_range(0, 19))
                    0: len = $urandom_range(60, 70);
                    1, 2: len = $urandom_range(9, 24);
                    default: len = $urandom_range(1, 8);
                endcase
            end
            flavor = $urandom_range(0, 5);
            if (flavor > 3) flavor = 0;
            frame_buf.delete();
            for (int i = 0; i < len; i++) frame_buf.push_back(pick_raw(flavor));
            send_frame();
            rf++;
        end

        in_ch.valid <= 1'b0;
        while (sb.scaled_due.size() != 0) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (60) @(posedge i_clk);

        $display("covered %0d frames from %0d samples, %0d results checked, %0d register writes",
                 sb.frames, items_sent, sb.checked, cfg_writes);
        if (sb.scaled_due.size() != 0) begin
            $display("%0d results never arrived", sb.scaled_due.size());
            sb.mismatches += sb.scaled_due.size();
        end
        $display("mismatches: %0d, final drain %0d cycles", sb.mismatches, wait_cycles);
        if (sb.mismatches == 0) begin
            $display("[audio_peak_normalizer] OK");
        end else begin
            $display("[audio_peak_normalizer] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/apn_pkg.sv
rtl/core/apn_ifs.sv
rtl/core/apn_ram.sv
rtl/core/apn_div.sv
rtl/core/audio_peak_normalizer.sv
tb/audio_peak_normalizer_tb.sv
